// ----- src/assert_macros.svh -----
// Assertion macros used by the RTL of the PID controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/pid_ctrl_pkg.sv -----
// Package with widths, register indexes and limits of the PID controller.
`default_nettype none

package pid_ctrl_pkg;

    localparam int FRACTION_BITS_DEF = 12;
    localparam int ERROR_WIDTH_DEF   = 16;
    localparam int GAIN_WIDTH        = 24;
    localparam int DRIVE_WIDTH       = 32;
    localparam int APB_DATA_WIDTH    = 32;
    localparam int CFG_ADDR_WIDTH    = 4;
    localparam int CFG_INDEX_WIDTH   = 2;

    typedef logic [CFG_INDEX_WIDTH-1:0] t_reg_index;

    localparam t_reg_index REG_KP = 2'd0;
    localparam t_reg_index REG_KI = 2'd1;
    localparam t_reg_index REG_KD = 2'd2;

    localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MAX = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
    localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MIN = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};

endpackage

`default_nettype wire

// ----- src/pid_controller_top.sv -----
// Discrete PID controller: one error sample in, one saturated drive value out.
// An accepted input transaction is registered in the input stage, then in the output register.
// Throughput: one sample per cycle unless the output stalls; the integral update and the
// ki*sum multiply sit in separate stages, so the accumulator loop closes in the input stage.
// Reset (i_rst_n low, synchronous) clears the gains, the integral sum, the previous error
// and all valid flags.
`default_nettype none

`include "assert_macros.svh"

module pid_controller_top
    import pid_ctrl_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int ERROR_WIDTH   = ERROR_WIDTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,

    // Configuration port (APB style).
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [CFG_ADDR_WIDTH-1:0]             paddr,
    input  wire logic [APB_DATA_WIDTH-1:0]             pwdata,
    output logic      [APB_DATA_WIDTH-1:0]             prdata,
    output logic                                       pready,

    // Error sample stream.
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata: error [ERROR_WIDTH-1:0], zero padding above up to a whole byte.
    input  wire logic [((ERROR_WIDTH+7)/8)*8-1:0]      s_axis_tdata,

    // Drive stream.
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // tdata: drive [31:0].
    output logic      [DRIVE_WIDTH-1:0]                m_axis_tdata,
    // tuser: saturated [0].
    output logic                                       m_axis_tuser
);

    localparam int DIFF_W = ERROR_WIDTH + 1;
    localparam int SUM_W  = DRIVE_WIDTH + 1;
    localparam int PP_W   = GAIN_WIDTH + ERROR_WIDTH;
    localparam int PI_W   = GAIN_WIDTH + DRIVE_WIDTH;
    localparam int PD_W   = GAIN_WIDTH + DIFF_W;
    // Three products of at most 56 bits each need two guard bits for their sum; ACC_W gives three.
    localparam int ACC_W  = GAIN_WIDTH + DRIVE_WIDTH + 3;

    // ------------------------------------------------------------------
    // Configuration registers. pready is tied high, so a write completes in
    // the access cycle. The register index is taken from the word address.
    // ------------------------------------------------------------------
    logic signed [GAIN_WIDTH-1:0] r_kp;
    logic signed [GAIN_WIDTH-1:0] r_ki;
    logic signed [GAIN_WIDTH-1:0] r_kd;

    logic       cfg_wr;
    t_reg_index cfg_index;
    logic       ki_clear;

    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite & pready;
    assign cfg_index = paddr[CFG_ADDR_WIDTH-1:2];
    // Writing a zero integral gain also empties the integral sum.
    assign ki_clear  = cfg_wr && (cfg_index == REG_KI) && (pwdata[GAIN_WIDTH-1:0] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_ki <= '0;
            r_kd <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_KP: r_kp <= pwdata[GAIN_WIDTH-1:0];
                REG_KI: r_ki <= pwdata[GAIN_WIDTH-1:0];
                REG_KD: r_kd <= pwdata[GAIN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Reads return the gain sign-extended to the bus width.
    always_comb begin
        case (cfg_index)
            REG_KP:  prdata = {{(APB_DATA_WIDTH-GAIN_WIDTH){r_kp[GAIN_WIDTH-1]}}, r_kp};
            REG_KI:  prdata = {{(APB_DATA_WIDTH-GAIN_WIDTH){r_ki[GAIN_WIDTH-1]}}, r_ki};
            REG_KD:  prdata = {{(APB_DATA_WIDTH-GAIN_WIDTH){r_kd[GAIN_WIDTH-1]}}, r_kd};
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. The output register frees up when its transaction is taken,
    // and the input stage moves forward whenever the output register can
    // load, so a new sample is taken in every cycle under full flow.
    // ------------------------------------------------------------------
    logic r_s1_vld;
    logic r_out_vld;
    logic out_load_ok;
    logic s1_move;
    logic in_accept;

    assign out_load_ok   = !r_out_vld || m_axis_tready;
    assign s1_move       = r_s1_vld && out_load_ok;
    assign s_axis_tready = !r_s1_vld || s1_move;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Input stage: saturating integral update and error difference.
    // ------------------------------------------------------------------
    logic signed [DRIVE_WIDTH-1:0] r_sum;
    logic signed [ERROR_WIDTH-1:0] r_prev;

    logic signed [ERROR_WIDTH-1:0] in_err;
    logic signed [SUM_W-1:0]       sum_wide;
    logic signed [DRIVE_WIDTH-1:0] n_sum;
    logic                          sum_clamped;
    logic signed [DIFF_W-1:0]      n_diff;

    assign in_err = s_axis_tdata[ERROR_WIDTH-1:0];

    always_comb begin
        sum_wide    = SUM_W'(r_sum) + SUM_W'(in_err);
        // The sum overflowed 32 bits when its two top bits disagree.
        sum_clamped = sum_wide[SUM_W-1] != sum_wide[SUM_W-2];
        if (sum_clamped) begin
            n_sum = sum_wide[SUM_W-1] ? DRIVE_MIN : DRIVE_MAX;
        end else begin
            n_sum = sum_wide[DRIVE_WIDTH-1:0];
        end
        n_diff = DIFF_W'(in_err) - DIFF_W'(r_prev);
    end

    logic signed [ERROR_WIDTH-1:0] r_s1_err;
    logic signed [DIFF_W-1:0]      r_s1_diff;
    logic signed [DRIVE_WIDTH-1:0] r_s1_sum;
    logic                          r_s1_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_prev   <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (ki_clear) begin
                r_sum <= '0;
            end else if (in_accept) begin
                r_sum <= n_sum;
            end
            if (in_accept) begin
                r_prev   <= in_err;
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_err  <= in_err;
            r_s1_diff <= n_diff;
            r_s1_sum  <= n_sum;
            r_s1_hit  <= sum_clamped;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: three products, their sum, floor shift and clamp.
    // ------------------------------------------------------------------
    logic signed [PP_W-1:0]        prod_p;
    logic signed [PI_W-1:0]        prod_i;
    logic signed [PD_W-1:0]        prod_d;
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       acc_shr;
    logic                          drive_clamped;
    logic signed [DRIVE_WIDTH-1:0] n_drive;

    always_comb begin
        prod_p  = PP_W'(r_kp) * PP_W'(r_s1_err);
        prod_i  = PI_W'(r_ki) * PI_W'(r_s1_sum);
        prod_d  = PD_W'(r_kd) * PD_W'(r_s1_diff);
        acc     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
        // Arithmetic shift rounds toward minus infinity.
        acc_shr = acc >>> FRACTION_BITS;
        // In range only when all bits from the drive sign bit upward agree.
        drive_clamped = !((&acc_shr[ACC_W-1:DRIVE_WIDTH-1]) ||
                          (~|acc_shr[ACC_W-1:DRIVE_WIDTH-1]));
        if (drive_clamped) begin
            n_drive = acc_shr[ACC_W-1] ? DRIVE_MIN : DRIVE_MAX;
        end else begin
            n_drive = acc_shr[DRIVE_WIDTH-1:0];
        end
    end

    logic [DRIVE_WIDTH-1:0] r_out_drive;
    logic                   r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_drive <= n_drive;
            r_out_sat   <= r_s1_hit || drive_clamped;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_drive;
    assign m_axis_tuser  = r_out_sat;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A zero integral gain write leaves an empty integral sum behind.
    `ASSERT_NEXT(a_ki_zero_clears_sum, i_clk, i_rst_n, ki_clear, r_sum == '0)
    // An accepted sample always occupies the input stage in the next cycle.
    `ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, in_accept, r_s1_vld)
    // A held input stage keeps its sample until the output register takes it.
    `ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_vld && !out_load_ok,
                 r_s1_vld && $stable(r_s1_err) && $stable(r_s1_sum))
    // With both stages full and the output stalled, no new sample is taken.
    `ASSERT_IMPLY(a_full_backpressure, i_clk, i_rst_n,
                  r_s1_vld && r_out_vld && !m_axis_tready, !s_axis_tready)

endmodule

`default_nettype wire
